[src/htwd_pkg.sv]
package htwd_pkg;

  // Default table depth
  localparam int NODES_DEFAULT = 512;

  localparam int IDX_W  = 9;
  localparam int SYM_W  = 8;
  localparam int CFG_W  = 9;
  localparam int NODE_W = 1 + SYM_W + 2 * IDX_W;

  // Configuration register indexes
  localparam logic [0:0] CFG_PADDING = 1'b0;
  localparam logic [0:0] CFG_ROOT    = 1'b1;

  typedef enum logic [0:0] {
    KIND_NODE = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Node table entry: leaf, symbol, left child, right child
  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] node_index;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] node_left;
    logic [IDX_W-1:0] node_right;
    logic [7:0]       data_byte;
    logic             last_byte;
  } htwd_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_of_run;
  } htwd_out_t;

  function automatic logic [IDX_W-1:0] child_sel(node_t n, logic b);
    return b ? n.right : n.left;
  endfunction

endpackage

[src/htwd_ram.sv]
module htwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/huffman_tree_walk_decoder_top.sv]
// Huffman tree-walk decoder: one node-table read per compressed bit, plus one more
// for each walk that starts at an inner root. A node load is written while idle; a
// data byte is accepted, walked bit by bit, then flushed.
// Throughput is set by the single-read node table: one tree step per cycle while the
// output does not stall. Each symbol is held until the next symbol of the byte is
// found; the last one leaves from the flush state.
// Reset (rst_ni low, async) clears the walk, the output stage and both config
// registers; the node table is not cleared and must be loaded before use.
module huffman_tree_walk_decoder_top #(
  parameter int NODES = htwd_pkg::NODES_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  htwd_pkg::htwd_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output htwd_pkg::htwd_out_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [htwd_pkg::CFG_W-1:0] cfg_wdata_i
);
  import htwd_pkg::*;

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  // Index is inside the table; anything beyond reads as an all-zero inner node
  function automatic logic in_range(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(NODES);
  endfunction

  // FSM and walk state
  state_e           state_q, state_d;
  logic             active_q, active_d;     // walk under way, cur_q valid
  node_t            cur_q, cur_d;           // entry of the current inner node
  logic [IDX_W-1:0] cur_idx_q, cur_idx_d;   // table index of cur_q
  logic             rd_root_q, rd_root_d;   // outstanding read is the root
  logic             oob_q, oob_d;           // outstanding read was out of table
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;     // index of the outstanding read
  logic [2:0]       bit_q, bit_d;           // bit served by the outstanding read
  logic [2:0]       limit_q, limit_d;       // lowest bit used in this byte
  logic [7:0]       byte_q, byte_d;
  logic             last_q, last_d;

  // Config registers
  logic [2:0]       padding_q, padding_d;
  logic [IDX_W-1:0] root_q, root_d;

  // Pending symbol (held until we know whether it is the last of the byte)
  logic             pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0] pend_sym_q, pend_sym_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  htwd_out_t        out_q, out_d;

  // Node table ports
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] rd_idx;
  logic [NODE_W-1:0] mem_rdata;
  node_t            wr_node;

  // Step decode
  node_t            ent;
  logic             consumed, emit, go_child, done, stall, out_free;
  logic [2:0]       nbit;

  assign wr_node = '{leaf:   in_data_i.node_is_leaf,
                     symbol: in_data_i.node_symbol,
                     left:   in_data_i.node_left,
                     right:  in_data_i.node_right};

  htwd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(in_data_i.node_index)),
    .wdata_i (wr_node),
    .re_i    (mem_re),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign nbit        = bit_q - 3'd1;

  // Decode what the returning read means for the walk
  always_comb begin
    ent      = oob_q ? '0 : node_t'(mem_rdata);
    consumed = 1'b0;
    emit     = 1'b0;
    go_child = 1'b0;
    if (rd_root_q) begin
      // leaf root: bit is used up with no symbol
      if (ent.leaf) begin
        consumed = 1'b1;
      end else begin
        go_child = 1'b1;
      end
    end else begin
      consumed = 1'b1;
      emit     = ent.leaf;
    end
    done  = consumed && (bit_q == limit_q);
    stall = (state_q == ST_RUN) && emit && pend_valid_q && !out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_data_i.kind == KIND_DATA)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!stall && done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    active_d     = active_q;
    cur_d        = cur_q;
    cur_idx_d    = cur_idx_q;
    rd_root_d    = rd_root_q;
    bit_d        = bit_q;
    limit_d      = limit_q;
    byte_d       = byte_q;
    last_d       = last_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    padding_d    = padding_q;
    root_d       = root_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    rd_idx       = root_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PADDING: padding_d = cfg_wdata_i[2:0];
        CFG_ROOT:    root_d    = cfg_wdata_i;
        default:     ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.kind == KIND_NODE) begin
            mem_we = in_range(in_data_i.node_index);
            // a parked walk sees a rewrite of its current node
            if (active_q && mem_we && (in_data_i.node_index == cur_idx_q)) begin
              cur_d = wr_node;
            end
          end else begin
            byte_d  = in_data_i.data_byte;
            last_d  = in_data_i.last_byte;
            limit_d = in_data_i.last_byte ? padding_q : 3'd0;
            bit_d   = 3'd7;
            mem_re  = 1'b1;
            if (active_q) begin
              rd_idx    = child_sel(cur_q, in_data_i.data_byte[7]);
              rd_root_d = 1'b0;
            end else begin
              rd_idx    = root_q;
              rd_root_d = 1'b1;
            end
          end
        end
      end
      ST_RUN: begin
        if (!stall) begin
          if (go_child) begin
            // inner root: start the walk, same bit picks the child
            cur_d     = ent;
            cur_idx_d = rd_idx_q;
            active_d  = 1'b1;
            mem_re    = 1'b1;
            rd_idx    = child_sel(ent, byte_q[bit_q]);
            rd_root_d = 1'b0;
          end else begin
            if (emit) begin
              active_d     = 1'b0;
              pend_sym_d   = ent.symbol;
              pend_valid_d = 1'b1;
              if (pend_valid_q) begin
                out_valid_d = 1'b1;
                out_d       = '{symbol: pend_sym_q, last_of_run: 1'b0};
              end
            end else if (!rd_root_q) begin
              cur_d     = ent;
              cur_idx_d = rd_idx_q;
            end
            if (done) begin
              if (last_q) begin
                active_d = 1'b0;
              end
            end else begin
              bit_d  = nbit;
              mem_re = 1'b1;
              if (!rd_root_q && !ent.leaf) begin
                rd_idx    = child_sel(ent, byte_q[nbit]);
                rd_root_d = 1'b0;
              end else begin
                rd_idx    = root_q;
                rd_root_d = 1'b1;
              end
            end
          end
        end
      end
      ST_FINISH: begin
        if (pend_valid_q && out_free) begin
          out_valid_d  = 1'b1;
          out_d        = '{symbol: pend_sym_q, last_of_run: 1'b1};
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase

    oob_d    = oob_q;
    rd_idx_d = rd_idx_q;
    if (mem_re) begin
      oob_d    = !in_range(rd_idx);
      rd_idx_d = rd_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= 1'b0;
      rd_root_q    <= 1'b0;
      oob_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      padding_q    <= 3'd0;
      root_q       <= '0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      rd_root_q    <= rd_root_d;
      oob_q        <= oob_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      padding_q    <= padding_d;
      root_q       <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cur_idx_q  <= cur_idx_d;
    rd_idx_q   <= rd_idx_d;
    bit_q      <= bit_d;
    limit_q    <= limit_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    pend_sym_q <= pend_sym_d;
    out_q      <= out_d;
  end

  // Table writes only happen between bytes
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("node table written during a walk");

  // Walk never runs below the last used bit
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (bit_q >= limit_q))
    else $error("bit position below padding limit");

  // A root read is only issued when no walk is under way
  a_root_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && rd_root_q) |-> !active_q)
    else $error("root read while walk active");

  // Stall keeps the step in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> ((state_q == ST_RUN) && $stable(bit_q) && $stable(rd_root_q)))
    else $error("walk advanced during output stall");

  // Byte end drains the pending symbol before the next transaction
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && (state_d == ST_IDLE)) |=> !pend_valid_q)
    else $error("pending symbol left after byte end");

endmodule

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import htwd_pkg::*;

  localparam int NODES        = NODES_DEFAULT;
  localparam int DRAIN_CYCLES = 60;    // covers a zero-symbol byte still in the block
  localparam int PHASE_ITEMS  = 92;    // per random phase, tree loads included
  localparam int HOLD_CYCLES  = 300;   // long receiver back-pressure stretch

  // ---------------------------------------------------------------------------
  // Scoreboard: its own node table and walk state; predicts the symbols each
  // accepted transaction decodes and checks them in order against the output.
  // ---------------------------------------------------------------------------
  class htwd_symbol_sb;
    node_t          node_mem [NODES];
    logic [IDX_W-1:0] walk_pos;
    bit             walking;
    logic [2:0]     pad_bits;
    logic [IDX_W-1:0] root_sel;
    htwd_out_t      pending_syms [$];
    int             errors;
    int             n_checked;
    int             n_nodes;
    int             n_bytes;

    function new();
      foreach (node_mem[i]) node_mem[i] = '0;
      walk_pos  = '0;
      walking   = 1'b0;
      pad_bits  = '0;
      root_sel  = '0;
      errors    = 0;
      n_checked = 0;
      n_nodes   = 0;
      n_bytes   = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_PADDING) pad_bits = val[2:0];
      else                    root_sel = val[IDX_W-1:0];
    endfunction

    function int pending();
      return pending_syms.size();
    endfunction

    function void note_item(htwd_in_t it);
      int        lo;
      int        b;
      int        made;
      node_t     nd;
      htwd_out_t sym;
      if (it.kind == KIND_NODE) begin
        n_nodes++;
        node_mem[it.node_index] = {it.node_is_leaf, it.node_symbol, it.node_left, it.node_right};
        return;
      end
      n_bytes++;
      lo   = it.last_byte ? int'(pad_bits) : 0;
      made = 0;
      for (b = 7; b >= lo; b--) begin
        if (!walking) begin
          walk_pos = root_sel;
          // leaf at the root: the bit decodes nothing
          if (!node_mem[walk_pos].leaf) walking = 1'b1;
        end
        if (walking) begin
          nd       = node_mem[walk_pos];
          walk_pos = it.data_byte[b] ? nd.right : nd.left;
          nd       = node_mem[walk_pos];
          if (nd.leaf) begin
            sym.symbol      = nd.symbol;
            sym.last_of_run = 1'b0;
            pending_syms.push_back(sym);
            made++;
            walking  = 1'b0;
            walk_pos = root_sel;
          end
        end
      end
      if (made > 0) begin
        sym = pending_syms.pop_back();
        sym.last_of_run = 1'b1;
        pending_syms.push_back(sym);
      end
      if (it.last_byte) begin
        walking  = 1'b0;
        walk_pos = root_sel;
      end
    endfunction

    function void check_symbol(htwd_out_t got);
      htwd_out_t exp_sym;
      if (pending_syms.size() == 0) begin
        errors++;
        $display("%0t: unexpected symbol 0x%02h last %0b, nothing pending",
                 $time, got.symbol, got.last_of_run);
        return;
      end
      exp_sym = pending_syms.pop_front();
      n_checked++;
      if (got.symbol !== exp_sym.symbol) begin
        errors++;
        $display("%0t: symbol mismatch: expected 0x%02h, actual 0x%02h",
                 $time, exp_sym.symbol, got.symbol);
      end
      if (got.last_of_run !== exp_sym.last_of_run) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                 $time, exp_sym.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input has a known value from time 0.
  // ---------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  htwd_in_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  htwd_out_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [0:0]           cfg_idx_i   = CFG_PADDING;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  huffman_tree_walk_decoder_top #(.NODES(NODES)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  htwd_symbol_sb sb = new();

  // Traffic shaping knobs, percent per cycle; hold_left is a pending
  // receiver hold-off, counted down by the receiver process itself.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  // Table entries written so far. Inner-node children are only ever drawn
  // from this set, so the walk never touches an unwritten entry.
  bit written [NODES];
  int written_list [$];

  // ---------------------------------------------------------------------------
  // Receiver: ready changes on the falling edge only.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Output monitor: one check per accepted output transaction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_symbol(out_data_o);
  end

  // ---------------------------------------------------------------------------
  // Transaction builders. Fields the block ignores still get random values
  // so every input bit toggles.
  // ---------------------------------------------------------------------------
  function automatic htwd_in_t noisy_item();
    logic [63:0] noise;
    noise = {$urandom(), $urandom()};
    return noise[$bits(htwd_in_t)-1:0];
  endfunction

  function automatic htwd_in_t data_item(logic [7:0] b, logic last);
    htwd_in_t it;
    it           = noisy_item();
    it.kind      = KIND_DATA;
    it.data_byte = b;
    it.last_byte = last;
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] any_written();
    return IDX_W'(written_list[$urandom_range(written_list.size() - 1)]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called on a falling edge, returns on a falling edge with valid
  // still high; the next call keeps it high unless it draws an idle gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input htwd_in_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_node(input logic [IDX_W-1:0] idx, input logic leaf,
                           input logic [SYM_W-1:0] sym,
                           input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r);
    htwd_in_t it;
    it              = noisy_item();
    it.kind         = KIND_NODE;
    it.node_index   = idx;
    it.node_is_leaf = leaf;
    it.node_symbol  = sym;
    it.node_left    = l;
    it.node_right   = r;
    send_item(it);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(int'(idx));
    end
  endtask

  // Lower valid, wait for every pending symbol, then let the block settle:
  // bytes that decode nothing may still be in flight.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register write; only issued while the block is idle.
  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random code tree, built bottom-up: leaves first, then inner nodes joining
  // two existing subtrees, so children are always written before parents.
  task automatic build_tree(input int n_leaves, output logic [IDX_W-1:0] root_out,
                            output int n_sent);
    bit              used [NODES];
    int              pool [$];
    int              a;
    int              b;
    int              pos;
    logic [IDX_W-1:0] idx;
    n_sent = 0;
    for (int k = 0; k < n_leaves + n_leaves - 1; k++) begin
      do idx = IDX_W'($urandom_range(NODES - 1)); while (used[idx]);
      used[idx] = 1'b1;
      if (k < n_leaves) begin
        // leaf children are don't-care for a fresh walk, but a walk parked on
        // this index follows them, so they point at written entries
        send_node(idx, 1'b1, SYM_W'($urandom_range(255)), any_written(), any_written());
      end else begin
        pos = $urandom_range(pool.size() - 1);
        a   = pool[pos];
        pool.delete(pos);
        pos = $urandom_range(pool.size() - 1);
        b   = pool[pos];
        pool.delete(pos);
        send_node(idx, 1'b0, SYM_W'($urandom_range(255)), IDX_W'(a), IDX_W'(b));
      end
      pool.push_back(int'(idx));
      n_sent++;
    end
    root_out = IDX_W'(pool[0]);
  endtask

  // ---------------------------------------------------------------------------
  // Main stimulus
  // ---------------------------------------------------------------------------
  localparam logic [IDX_W-1:0] T_ROOT = 9'd0;    // inner: 0 -> A, 1 -> X
  localparam logic [IDX_W-1:0] T_X    = 9'd170;  // inner: 0 -> B, 1 -> C
  localparam logic [IDX_W-1:0] T_A    = 9'd511;  // leaf 0x00, code 0
  localparam logic [IDX_W-1:0] T_B    = 9'd341;  // leaf 0xFF, code 10
  localparam logic [IDX_W-1:0] T_C    = 9'd256;  // leaf 0x5A, code 11

  initial begin
    int               send_pct [5];
    int               recv_pct [5];
    logic [2:0]       pad_sel [5];
    logic [IDX_W-1:0] root_idx;
    int               n_sent;
    int               phase_items;

    send_pct = '{0, 53, 0, 30, 0};
    recv_pct = '{0, 0, 53, 30, 0};
    pad_sel  = '{3'd7, 3'd0, 3'd5, 3'd7, 3'd0};

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- Directed: small hand-built tree, codes 0 / 10 / 11 ----
    send_node(T_A, 1'b1, 8'h00, 9'd0, 9'd0);
    send_node(T_B, 1'b1, 8'hFF, 9'd511, 9'd511);
    send_node(T_C, 1'b1, 8'h5A, 9'd170, 9'd341);
    send_node(T_X, 1'b0, 8'hC3, T_B, T_C);      // inner node with a nonzero symbol
    send_node(T_ROOT, 1'b0, 8'h00, T_A, T_X);
    wait_drained();
    write_reg(CFG_PADDING, '0);
    write_reg(CFG_ROOT, CFG_W'(T_ROOT));

    send_item(data_item(8'h00, 1'b0));          // eight symbols from one byte
    send_item(data_item(8'hFF, 1'b0));
    send_item(data_item(8'hAA, 1'b0));
    send_item(data_item(8'hC0, 1'b0));
    send_item(data_item(8'h01, 1'b0));          // ends mid-code
    send_item(data_item(8'h80, 1'b0));          // code finished across the byte boundary
    send_item(data_item(8'h01, 1'b1));          // partial code dropped at stream end
    send_item(data_item(8'h80, 1'b0));          // walk restarted from the root

    // padding extremes: only the MSB used; 0x80 leaves a partial code, 0x00 one symbol
    wait_drained();
    write_reg(CFG_PADDING, CFG_W'(7));
    send_item(data_item(8'h80, 1'b1));
    send_item(data_item(8'h00, 1'b1));
    wait_drained();
    write_reg(CFG_PADDING, CFG_W'(3));
    send_item(data_item(8'hFF, 1'b1));
    send_item(data_item(8'h07, 1'b1));          // padding bits set but unused

    // root pointing at a leaf: bytes decode nothing
    wait_drained();
    write_reg(CFG_ROOT, CFG_W'(T_A));
    send_item(data_item(8'hFF, 1'b0));
    send_item(data_item(8'h00, 1'b1));

    // node rewrite while a walk is parked mid-code
    wait_drained();
    write_reg(CFG_ROOT, CFG_W'(T_ROOT));
    write_reg(CFG_PADDING, '0);
    send_item(data_item(8'h01, 1'b0));
    send_node(T_C, 1'b1, 8'h7E, 9'd0, 9'd0);
    send_item(data_item(8'h80, 1'b0));

    // ---- Random phases: fresh tree each phase, then a random byte stream ----
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      send_idle_pct  = send_pct[p];
      recv_stall_pct = recv_pct[p];
      write_reg(CFG_PADDING, CFG_W'(pad_sel[p]));
      build_tree($urandom_range(2, 24), root_idx, n_sent);
      wait_drained();
      write_reg(CFG_ROOT, CFG_W'(root_idx));
      phase_items = n_sent;
      // last phase: stall the receiver for a long stretch while bytes keep
      // coming, so the block backs up and drops in_ready
      if (p == 4) hold_left = HOLD_CYCLES;
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(99) < 8) begin
          // stray node rewrite; inner children stay within written entries
          send_node(IDX_W'($urandom_range(NODES - 1)), 1'($urandom_range(1)),
                    SYM_W'($urandom_range(255)), any_written(), any_written());
        end else begin
          case ($urandom_range(9))
            0:       send_item(data_item(8'h00, 1'($urandom_range(7) == 0)));
            1:       send_item(data_item(8'hFF, 1'($urandom_range(7) == 0)));
            default: send_item(data_item(8'($urandom_range(255)), 1'($urandom_range(7) == 0)));
          endcase
        end
        phase_items++;
      end
    end

    // ---- Wrap-up ----
    wait_drained();
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected symbols never arrived", $time, sb.pending());
    end
    $display("Covered %0d node loads and %0d data bytes in five traffic phases,",
             sb.n_nodes, sb.n_bytes);
    $display("%0d decoded symbols compared, %0d mismatches.", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("huffman_tree_walk_decoder_top test passed");
    end else begin
      $display("huffman_tree_walk_decoder_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("%0t: watchdog expired, %0d symbols still pending", $time, sb.pending());
    $display("huffman_tree_walk_decoder_top test failed");
    $finish;
  end

endmodule
